### hdl/ton_pkg.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Byte codes, option numbers, request and job types shared by the design.
// ----------------------------------------------------------------------------
package ton_pkg;

  localparam logic [7:0] IAC  = 8'd255;
  localparam logic [7:0] DONT = 8'd254;
  localparam logic [7:0] DO   = 8'd253;
  localparam logic [7:0] WONT = 8'd252;
  localparam logic [7:0] WILL = 8'd251;
  localparam logic [7:0] SB   = 8'd250;
  localparam logic [7:0] SE   = 8'd240;

  localparam logic [7:0] OPTION_BINARY = 8'd0;
  localparam logic [7:0] OPTION_ECHO   = 8'd1;
  localparam logic [7:0] OPTION_SGA    = 8'd3;
  localparam logic [7:0] OPTION_TTYPE  = 8'd24;
  localparam logic [7:0] OPTION_NAWS   = 8'd31;

  localparam logic [7:0] TERMTYPE_IS   = 8'd0;
  localparam logic [7:0] TERMTYPE_SEND = 8'd1;

  localparam logic [31:0] ANSI_NAME = 32'h4953_4E41;
  localparam int          NAME_BYTES = 8;

  localparam logic [15:0] COLUMNS_MIN   = 16'd20;
  localparam logic [15:0] ROWS_MIN      = 16'd5;
  localparam logic [15:0] COLUMNS_RESET = 16'd80;
  localparam logic [15:0] ROWS_RESET    = 16'd24;
  localparam logic [63:0] NAME_RESET    = 64'd1230196289;
  localparam logic [3:0]  NAME_LEN_RESET = 4'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_NEG,
    PS_SUBOPT,
    PS_SUBDATA,
    PS_SUBIAC
  } parse_state_e;

  typedef enum logic [1:0] {
    VERB_WILL,
    VERB_WONT,
    VERB_DO,
    VERB_DONT
  } verb_e;

  typedef enum logic [1:0] {
    JOB_DISPLAY,
    JOB_CMD,
    JOB_NAWS,
    JOB_TTYPE
  } job_kind_e;

  typedef enum logic [3:0] {
    REG_COLUMNS,
    REG_ROWS,
    REG_NAME,
    REG_NAME_LEN
  } cfg_reg_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  byte_a;
    logic [7:0]  option;
    logic        echo;
  } job_t;

  typedef struct packed {
    logic        push;
    job_t        job;
  } queue_wr_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    job_t        head;
  } queue_rd_t;

  typedef struct packed {
    logic [15:0] columns;
    logic [15:0] rows;
    logic [63:0] name;
    logic [3:0]  name_len;
  } term_cfg_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'd133 || c == 8'd160;
  endfunction

endpackage

### hdl/ton_front.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator front end
// Parses rx bytes one per cycle unless stalled; queues display and reply jobs.
// ----------------------------------------------------------------------------
module ton_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_full_i,
  output ton_pkg::queue_wr_t q_wr_o
);
  import ton_pkg::*;

  parse_state_e state_q, state_d;
  verb_e        verb_q, verb_d;
  logic [7:0]   sub_option_q, sub_option_d;
  logic [7:0]   sub_first_q, sub_first_d;
  logic         sub_has_q, sub_has_d;
  logic         echo_q, echo_d;
  logic         accept;
  logic [7:0]   verb_off;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign verb_off   = rx_byte_i - WILL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= PS_DATA;
      verb_q       <= VERB_WILL;
      sub_option_q <= '0;
      sub_first_q  <= '0;
      sub_has_q    <= 1'b0;
      echo_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      verb_q       <= verb_d;
      sub_option_q <= sub_option_d;
      sub_first_q  <= sub_first_d;
      sub_has_q    <= sub_has_d;
      echo_q       <= echo_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    verb_d            = verb_q;
    sub_option_d      = sub_option_q;
    sub_first_d       = sub_first_q;
    sub_has_d         = sub_has_q;
    echo_d            = echo_q;
    q_wr_o.push       = 1'b0;
    q_wr_o.job.kind   = JOB_DISPLAY;
    q_wr_o.job.byte_a = rx_byte_i;
    q_wr_o.job.option = rx_byte_i;
    if (accept) begin
      case (state_q)
        PS_IAC: begin
          if (rx_byte_i == IAC) begin
            q_wr_o.push = 1'b1;
            state_d     = PS_DATA;
          end else if (rx_byte_i inside {WILL, WONT, DO, DONT}) begin
            verb_d  = verb_e'(verb_off[1:0]);
            state_d = PS_NEG;
          end else if (rx_byte_i == SB) begin
            state_d = PS_SUBOPT;
          end else begin
            state_d = PS_DATA;
          end
        end
        PS_NEG: begin
          q_wr_o.push     = 1'b1;
          q_wr_o.job.kind = JOB_CMD;
          case (verb_q)
            VERB_WILL: begin
              if (rx_byte_i inside {OPTION_BINARY, OPTION_SGA}) begin
                q_wr_o.job.byte_a = DO;
              end else if (rx_byte_i == OPTION_ECHO) begin
                echo_d            = 1'b1;
                q_wr_o.job.byte_a = DO;
              end else begin
                q_wr_o.job.byte_a = DONT;
              end
            end
            VERB_WONT: begin
              if (rx_byte_i == OPTION_ECHO) begin
                echo_d = 1'b0;
              end
              q_wr_o.job.byte_a = DONT;
            end
            VERB_DO: begin
              if (rx_byte_i inside {OPTION_BINARY, OPTION_SGA, OPTION_TTYPE}) begin
                q_wr_o.job.byte_a = WILL;
              end else if (rx_byte_i == OPTION_NAWS) begin
                q_wr_o.job.kind   = JOB_NAWS;
                q_wr_o.job.byte_a = WILL;
              end else begin
                q_wr_o.job.byte_a = WONT;
              end
            end
            default: begin
              q_wr_o.job.byte_a = WONT;
            end
          endcase
          state_d = PS_DATA;
        end
        PS_SUBOPT: begin
          sub_option_d = rx_byte_i;
          sub_has_d    = 1'b0;
          sub_first_d  = '0;
          state_d      = PS_SUBDATA;
        end
        PS_SUBDATA: begin
          if (rx_byte_i == IAC) begin
            state_d = PS_SUBIAC;
          end else if (!sub_has_q) begin
            sub_first_d = rx_byte_i;
            sub_has_d   = 1'b1;
          end
        end
        PS_SUBIAC: begin
          if (rx_byte_i == SE) begin
            if (sub_option_q == OPTION_TTYPE && sub_has_q &&
                sub_first_q == TERMTYPE_SEND) begin
              q_wr_o.push     = 1'b1;
              q_wr_o.job.kind = JOB_TTYPE;
            end
            sub_has_d   = 1'b0;
            sub_first_d = '0;
            state_d     = PS_DATA;
          end else begin
            if (rx_byte_i == IAC && !sub_has_q) begin
              sub_first_d = IAC;
              sub_has_d   = 1'b1;
            end
            state_d = PS_SUBDATA;
          end
        end
        default: begin
          if (rx_byte_i == IAC) begin
            state_d = PS_IAC;
          end else begin
            q_wr_o.push = 1'b1;
          end
        end
      endcase
    end
    q_wr_o.job.echo = echo_d;
  end

endmodule

### hdl/ton_queue.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator job queue
// Short first-in first-out buffer between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
module ton_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ton_pkg::queue_wr_t wr_i,
  input  logic               pop_i,
  output ton_pkg::queue_rd_t rd_o
);
  import ton_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign rd_o.empty = (count_q == '0);
  assign rd_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_o.head  = mem_q[rd_ptr_q];
  assign do_push    = wr_i.push && !rd_o.full;
  assign do_pop     = pop_i && !rd_o.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.job;
    end
  end

endmodule

### hdl/ton_back.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator back end
// Expands queued jobs into registered bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ton_back #(
  parameter int TermChars = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ton_pkg::queue_rd_t q_rd_i,
  output logic               q_pop_o,
  input  ton_pkg::term_cfg_t cfg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               remote_echo_o
);
  import ton_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [3:0] ci_q, ci_d;
  logic       dup_q, dup_d;
  logic       out_valid_q;
  logic       kind_q, last_q, echo_q;
  logic [7:0] byte_q;

  logic [3:0]            len;
  logic [NAME_BYTES-1:0] keep;
  logic [3:0]            first_idx, end_idx;
  logic                  name_empty;
  logic [3:0]            body_start, body_stop;
  logic [7:0]            body_byte;

  logic       adv;
  logic [7:0] cur_byte;
  logic       cur_esc, cur_final, cur_kind;
  logic       dup_needed, is_last;
  job_t       job;

  assign job = q_rd_i.head;

  always_comb begin
    len        = (cfg_i.name_len > 4'(TermChars)) ? 4'(TermChars) : cfg_i.name_len;
    first_idx  = '0;
    end_idx    = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      keep[i] = (4'(i) < len) && !is_blank(cfg_i.name[8*i +: 8]);
    end
    for (int i = NAME_BYTES - 1; i >= 0; i--) begin
      if (keep[i]) begin
        first_idx = 4'(i);
      end
    end
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (keep[i]) begin
        end_idx = 4'(i + 1);
      end
    end
    name_empty = (keep == '0);
    body_start = name_empty ? 4'd0 : first_idx;
    body_stop  = name_empty ? 4'd4 : end_idx;
    body_byte  = name_empty ? ANSI_NAME[8*ci_q[1:0] +: 8] : cfg_i.name[8*ci_q[2:0] +: 8];
  end

  always_comb begin
    cur_byte  = SE;
    cur_esc   = 1'b0;
    cur_final = 1'b0;
    cur_kind  = 1'b1;
    case (job.kind)
      JOB_DISPLAY: begin
        cur_byte  = job.byte_a;
        cur_final = 1'b1;
        cur_kind  = 1'b0;
      end
      JOB_CMD: begin
        case (pos_q)
          4'd0:    cur_byte = IAC;
          4'd1:    cur_byte = job.byte_a;
          default: cur_byte = job.option;
        endcase
        cur_final = (pos_q == 4'd2);
      end
      JOB_NAWS: begin
        case (pos_q)
          4'd0:    cur_byte = IAC;
          4'd1:    cur_byte = WILL;
          4'd2:    cur_byte = OPTION_NAWS;
          4'd3:    cur_byte = IAC;
          4'd4:    cur_byte = SB;
          4'd5:    cur_byte = OPTION_NAWS;
          4'd6:    cur_byte = cfg_i.columns[15:8];
          4'd7:    cur_byte = cfg_i.columns[7:0];
          4'd8:    cur_byte = cfg_i.rows[15:8];
          4'd9:    cur_byte = cfg_i.rows[7:0];
          4'd10:   cur_byte = IAC;
          default: cur_byte = SE;
        endcase
        cur_esc   = (pos_q >= 4'd6 && pos_q <= 4'd9);
        cur_final = (pos_q == 4'd11);
      end
      default: begin
        case (pos_q)
          4'd0:    cur_byte = IAC;
          4'd1:    cur_byte = SB;
          4'd2:    cur_byte = OPTION_TTYPE;
          4'd3:    cur_byte = TERMTYPE_IS;
          4'd4:    cur_byte = body_byte;
          4'd5:    cur_byte = IAC;
          default: cur_byte = SE;
        endcase
        cur_esc   = (pos_q == 4'd4) && !name_empty;
        cur_final = (pos_q == 4'd6);
      end
    endcase
  end

  assign adv        = !q_rd_i.empty && (!out_valid_q || !out_stall_i);
  assign dup_needed = cur_esc && (cur_byte == IAC) && !dup_q;
  assign is_last    = cur_final && !dup_needed;
  assign q_pop_o    = adv && is_last;

  always_comb begin
    pos_d = pos_q;
    ci_d  = ci_q;
    dup_d = dup_q;
    if (adv) begin
      if (is_last) begin
        pos_d = '0;
        dup_d = 1'b0;
      end else if (dup_needed) begin
        dup_d = 1'b1;
      end else begin
        dup_d = 1'b0;
        if (job.kind == JOB_TTYPE && pos_q == 4'd4) begin
          if (ci_q + 4'd1 == body_stop) begin
            pos_d = 4'd5;
          end else begin
            ci_d = ci_q + 4'd1;
          end
        end else begin
          pos_d = pos_q + 4'd1;
          if (pos_q == 4'd3) begin
            ci_d = body_start;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ci_q        <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      ci_q  <= ci_d;
      dup_q <= dup_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q <= cur_kind;
      byte_q <= cur_byte;
      last_q <= is_last;
      echo_q <= job.echo;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign last_o        = last_q;
  assign remote_echo_o = echo_q;

endmodule

### hdl/telnet_option_negotiator.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Receive-side Telnet parser with fixed option replies, window size and
// terminal type subnegotiation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o   rx_byte_i
// out       output     out_valid_o / out_stall_i kind_o, out_byte_o, last_o,
//                                                remote_echo_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The parser takes one received byte per cycle while the four-entry job
// queue has room. The reply sequencer emits one result byte per cycle
// while out_stall_i is low: one per display byte, 3 per option reply,
// up to 16 for a window size report and up to 22 for a terminal type
// reply. Bytes of the job at the queue head are registered in the output
// register. Reset is immediate; no clearing pass. A held out_stall_i
// freezes the output register, the queue then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
module telnet_option_negotiator #(
  parameter int TermChars = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        remote_echo_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import ton_pkg::*;

  term_cfg_t cfg_q;
  queue_wr_t q_wr;
  queue_rd_t q_rd;
  logic      q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns  <= COLUMNS_RESET;
      cfg_q.rows     <= ROWS_RESET;
      cfg_q.name     <= NAME_RESET;
      cfg_q.name_len <= NAME_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_COLUMNS: begin
          cfg_q.columns <= (cfg_data_i[15:0] < COLUMNS_MIN) ? COLUMNS_MIN : cfg_data_i[15:0];
        end
        REG_ROWS: begin
          cfg_q.rows <= (cfg_data_i[15:0] < ROWS_MIN) ? ROWS_MIN : cfg_data_i[15:0];
        end
        REG_NAME: begin
          cfg_q.name <= cfg_data_i;
        end
        REG_NAME_LEN: begin
          cfg_q.name_len <= cfg_data_i[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  ton_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_rd.full),
    .q_wr_o     (q_wr)
  );

  ton_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .rd_o   (q_rd)
  );

  ton_back #(
    .TermChars (TermChars)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_rd_i        (q_rd),
    .q_pop_o       (q_pop),
    .cfg_i         (cfg_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .last_o        (last_o),
    .remote_echo_o (remote_echo_o)
  );

endmodule

### hdl/ton_checker.sv
// ----------------------------------------------------------------------------
// Telnet option negotiator checker
// Port-level properties of the negotiator, bound to the top level.
// ----------------------------------------------------------------------------
module ton_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        kind_o,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic        remote_echo_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("stalled output request changed");

  a_display_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> last_o)
    else $error("display byte not marked last");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && kind_o)
    else $error("reply burst broken");

  a_burst_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> $stable(remote_echo_o))
    else $error("echo flag changed within one burst");

endmodule

bind telnet_option_negotiator ton_checker u_ton_checker (.*);
